// ===== design/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape block.
// Holds parse modes, status codes, character codes and the result word burst.
// No dependencies.
package jsu_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int MAX_BURST   = 4;

   typedef enum logic [2:0] {
      MODE_IDLE       = 3'd0,
      MODE_TEXT       = 3'd1,
      MODE_ESC        = 3'd2,
      MODE_HEX_FIRST  = 3'd3,
      MODE_SURR_BSL   = 3'd4,
      MODE_SURR_U     = 3'd5,
      MODE_HEX_SECOND = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      ST_DATA       = 3'd0,
      ST_DONE       = 3'd1,
      ST_BAD_ESCAPE = 3'd2,
      ST_BAD_HEX    = 3'd3,
      ST_BAD_SURR   = 3'd4,
      ST_CONTROL    = 3'd5,
      ST_NO_QUOTE   = 3'd6
   } status_type;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_BSL    = 8'h5C;
   localparam logic [7:0] CHAR_LC_B   = 8'h62;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;
   localparam logic [7:0] CHAR_LC_N   = 8'h6E;
   localparam logic [7:0] CHAR_LC_R   = 8'h72;
   localparam logic [7:0] CHAR_LC_T   = 8'h74;
   localparam logic [7:0] CHAR_LC_U   = 8'h75;
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;

   localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;

   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   typedef struct packed {
      logic [MAX_BURST-1:0][7:0] data;
      logic [2:0]                count;
      status_type                status;
      logic [15:0]               length;
   } burst_type;

endpackage

// ===== design/jsu_parser.sv =====
// Parse state machine: decodes one text byte per accepted word into a burst
// of up to four result words. Depends on jsu_pkg.
module jsu_parser import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   output burst_type  burst
);

   mode_type               mode_ff, mode_in;
   logic [1:0]             count_ff, count_in;
   logic [15:0]            accum_ff, accum_in;
   logic [15:0]            high_ff, high_in;
   logic [LENGTH_BITS-1:0] bcount_ff, bcount_in;
   logic                   bcount_clear;

   logic [4:0]             hex_val;
   logic                   hex_ok;
   logic [15:0]            accum_next;
   logic                   unit_done;
   logic                   is_high;
   logic                   is_low;
   logic [20:0]            pair_cp;
   logic [32:0]            bcount_wide;
   logic [15:0]            len_sat;
   logic [LENGTH_BITS:0]   bcount_sum;

   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [4:0] v;
      v = 5'd16;
      if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
      else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
      else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
      return v;
   endfunction

   function automatic burst_type one_word(input logic [7:0] b, input status_type st,
                                          input logic [15:0] len);
      burst_type r;
      r        = '0;
      r.data[0] = b;
      r.count  = 3'd1;
      r.status = st;
      r.length = len;
      return r;
   endfunction

   function automatic burst_type utf8_encode(input logic [20:0] u);
      burst_type r;
      r        = '0;
      r.status = ST_DATA;
      if (u <= 21'h7F) begin
         r.data[0] = u[7:0];
         r.count   = 3'd1;
      end else if (u <= 21'h7FF) begin
         r.data[0] = UTF8_LEAD2 | {3'b000, u[10:6]};
         r.data[1] = UTF8_CONT | {2'b00, u[5:0]};
         r.count   = 3'd2;
      end else if (u <= 21'hFFFF) begin
         r.data[0] = UTF8_LEAD3 | {4'b0000, u[15:12]};
         r.data[1] = UTF8_CONT | {2'b00, u[11:6]};
         r.data[2] = UTF8_CONT | {2'b00, u[5:0]};
         r.count   = 3'd3;
      end else begin
         r.data[0] = UTF8_LEAD4 | {5'b00000, u[20:18]};
         r.data[1] = UTF8_CONT | {2'b00, u[17:12]};
         r.data[2] = UTF8_CONT | {2'b00, u[11:6]};
         r.data[3] = UTF8_CONT | {2'b00, u[5:0]};
         r.count   = 3'd4;
      end
      return r;
   endfunction

   assign hex_val     = hex_decode(text_byte);
   assign hex_ok      = !hex_val[4];
   assign accum_next  = {accum_ff[11:0], hex_val[3:0]};
   assign unit_done   = hex_ok && (count_ff == 2'd3);
   assign is_high     = accum_next[15:10] == SURR_HIGH_TAG;
   assign is_low      = accum_next[15:10] == SURR_LOW_TAG;
   assign pair_cp     = SUPP_BASE + {1'b0, high_ff[9:0], accum_next[9:0]};
   assign bcount_wide = 33'(bcount_ff);
   assign len_sat     = (bcount_wide > 33'(LEN_MAX)) ? LEN_MAX : bcount_wide[15:0];
   assign bcount_sum  = (LENGTH_BITS+1)'(bcount_ff) + (LENGTH_BITS+1)'(burst.count);

   always_comb begin
      mode_in      = mode_ff;
      count_in     = count_ff;
      accum_in     = accum_ff;
      high_in      = high_ff;
      bcount_clear = 1'b0;
      unique case (mode_ff)
         MODE_TEXT: begin
            if (text_byte == CHAR_QUOTE) begin
               mode_in      = MODE_IDLE;
               bcount_clear = 1'b1;
            end else if (text_byte == CHAR_BSL) begin
               mode_in = MODE_ESC;
            end else if (text_byte < CHAR_SPACE) begin
               mode_in  = MODE_IDLE;
               count_in = '0;
               accum_in = '0;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_TEXT;
            case (text_byte)
               CHAR_QUOTE, CHAR_BSL, CHAR_SLASH, CHAR_LC_B, CHAR_LC_F, CHAR_LC_N,
               CHAR_LC_R, CHAR_LC_T: ;
               CHAR_LC_U: begin
                  mode_in  = MODE_HEX_FIRST;
                  count_in = '0;
                  accum_in = '0;
               end
               default: begin
                  mode_in  = MODE_IDLE;
                  count_in = '0;
                  accum_in = '0;
               end
            endcase
         end
         MODE_HEX_FIRST, MODE_HEX_SECOND: begin
            if (!hex_ok) begin
               mode_in  = MODE_IDLE;
               count_in = '0;
               accum_in = '0;
            end else if (!unit_done) begin
               accum_in = accum_next;
               count_in = count_ff + 2'd1;
            end else begin
               accum_in = accum_next;
               count_in = '0;
               if (mode_ff == MODE_HEX_FIRST) begin
                  if (is_high) begin
                     high_in = accum_next;
                     mode_in = MODE_SURR_BSL;
                  end else begin
                     mode_in = MODE_TEXT;
                  end
               end else if (is_low) begin
                  mode_in = MODE_TEXT;
               end else begin
                  mode_in  = MODE_IDLE;
                  accum_in = '0;
               end
            end
         end
         MODE_SURR_BSL: begin
            if (text_byte == CHAR_BSL) begin
               mode_in = MODE_SURR_U;
            end else begin
               mode_in  = MODE_IDLE;
               count_in = '0;
               accum_in = '0;
            end
         end
         MODE_SURR_U: begin
            count_in = '0;
            accum_in = '0;
            if (text_byte == CHAR_LC_U) mode_in = MODE_HEX_SECOND;
            else mode_in = MODE_IDLE;
         end
         default: begin
            if (text_byte == CHAR_QUOTE) begin
               mode_in      = MODE_TEXT;
               bcount_clear = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      burst = '0;
      unique case (mode_ff)
         MODE_TEXT: begin
            if (text_byte == CHAR_QUOTE) burst = one_word(CHAR_NUL, ST_DONE, len_sat);
            else if (text_byte == CHAR_BSL) burst = '0;
            else if (text_byte == CHAR_NUL) burst = one_word(CHAR_NUL, ST_NO_QUOTE, '0);
            else if (text_byte < CHAR_SPACE) burst = one_word(CHAR_NUL, ST_CONTROL, '0);
            else burst = one_word(text_byte, ST_DATA, '0);
         end
         MODE_ESC: begin
            case (text_byte)
               CHAR_QUOTE: burst = one_word(CHAR_QUOTE, ST_DATA, '0);
               CHAR_BSL:   burst = one_word(CHAR_BSL, ST_DATA, '0);
               CHAR_SLASH: burst = one_word(CHAR_SLASH, ST_DATA, '0);
               CHAR_LC_B:  burst = one_word(CHAR_BS, ST_DATA, '0);
               CHAR_LC_F:  burst = one_word(CHAR_FF, ST_DATA, '0);
               CHAR_LC_N:  burst = one_word(CHAR_LF, ST_DATA, '0);
               CHAR_LC_R:  burst = one_word(CHAR_CR, ST_DATA, '0);
               CHAR_LC_T:  burst = one_word(CHAR_TAB, ST_DATA, '0);
               CHAR_LC_U:  burst = '0;
               default:    burst = one_word(CHAR_NUL, ST_BAD_ESCAPE, '0);
            endcase
         end
         MODE_HEX_FIRST, MODE_HEX_SECOND: begin
            if (!hex_ok) begin
               burst = one_word(CHAR_NUL, ST_BAD_HEX, '0);
            end else if (unit_done) begin
               if (mode_ff == MODE_HEX_FIRST) begin
                  if (!is_high) burst = utf8_encode({5'b00000, accum_next});
               end else if (is_low) begin
                  burst = utf8_encode(pair_cp);
               end else begin
                  burst = one_word(CHAR_NUL, ST_BAD_SURR, '0);
               end
            end
         end
         MODE_SURR_BSL: begin
            if (text_byte != CHAR_BSL) burst = one_word(CHAR_NUL, ST_BAD_SURR, '0);
         end
         MODE_SURR_U: begin
            if (text_byte != CHAR_LC_U) burst = one_word(CHAR_NUL, ST_BAD_SURR, '0);
         end
         default: burst = '0;
      endcase
   end

   always_comb begin
      bcount_in = bcount_ff;
      if (bcount_clear) begin
         bcount_in = '0;
      end else if (burst.status == ST_DATA && burst.count != 3'd0) begin
         bcount_in = bcount_sum[LENGTH_BITS] ? '1 : bcount_sum[LENGTH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         count_ff  <= '0;
         accum_ff  <= '0;
         high_ff   <= '0;
         bcount_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         accum_ff  <= accum_in;
         high_ff   <= high_in;
         bcount_ff <= bcount_in;
      end
   end

endmodule

// ===== design/jsu_serializer.sv =====
// Result register: holds one burst and hands it out one word per cycle while out_ready is high.
// Depends on jsu_pkg.
module jsu_serializer import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  burst_type   burst,
   output logic        can_load,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_byte,
   output logic [2:0]  out_status,
   output logic [15:0] out_length,
   output logic        out_last
);

   burst_type  hold_ff;
   logic       valid_ff;
   logic [1:0] idx_ff;
   logic       take;

   assign out_valid  = valid_ff;
   assign take       = valid_ff && out_ready;
   assign out_last   = {1'b0, idx_ff} == (hold_ff.count - 3'd1);
   assign can_load   = !valid_ff || (take && out_last);
   assign out_byte   = hold_ff.data[idx_ff];
   assign out_status = hold_ff.status;
   assign out_length = hold_ff.length;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load && burst.count != 3'd0) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         if (out_last) valid_ff <= 1'b0;
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load && burst.count != 3'd0) hold_ff <= burst;
   end

endmodule

// ===== design/json_string_unescape_utf8.sv =====
// JSON string unescape with UTF-8 encoding of \u escapes.
// Top level: jsu_parser feeds jsu_serializer. Depends on jsu_pkg.
//
// Input channel req_valid/req_ready carries one byte of JSON text per word.
// Output channel rsp_valid/rsp_ready carries one decoded result word:
// a data byte, a done word with the decoded length, or an error code.
// rsp_last_of_run marks the final word caused by one input byte.
// The result register shows a byte's first result word in the cycle after
// it is accepted. Throughput: one byte per cycle while each byte gives at most
// one word and rsp_ready is high; a \u escape that encodes to several UTF-8
// bytes holds req_ready low while the register hands out one word per cycle.
// A stalled receiver holds the result register; a new byte is taken only
// once the last word of the held burst leaves, in the same cycle.
// Reset clears the parse state to waiting for an opening quote and empties
// the result register.
module json_string_unescape_utf8 import jsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_decoded_length,
   output logic        rsp_last_of_run
);

   logic      accept;
   burst_type burst;

   assign accept = req_valid && req_ready;

   jsu_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .burst     (burst)
   );

   jsu_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .burst      (burst),
      .can_load   (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_byte   (rsp_out_byte),
      .out_status (rsp_status),
      .out_length (rsp_decoded_length),
      .out_last   (rsp_last_of_run)
   );

endmodule
